// ----- design/erg_pkg.sv -----
// Package for the Euclidean rhythm generator.
// Holds the controller states, the command and status structs and the mask helper.
// Used by erg_ctrl, erg_dp and euclidean_rhythm_generator.
package erg_pkg;

  localparam int unsigned PatW = 64;
  localparam int unsigned CntW = 7;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_TAIL = 5'b00100,
    ST_ROT  = 5'b01000,
    ST_FIN  = 5'b10000
  } erg_state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic tail;
    logic rot_step;
    logic out_load;
  } erg_cmd_t;

  typedef struct packed {
    logic trivial;
    logic can_sub;
    logic last_level;
    logic lead_one;
  } erg_status_t;

  function automatic logic [PatW-1:0] low_mask(input logic [CntW-1:0] n);
    return ~({PatW{1'b1}} << n);
  endfunction

endpackage

// ----- design/euclidean_rhythm_generator.sv -----
// Euclidean rhythm generator: one request of step count, onset count and anti flag gives
// one 64-bit pattern word. After a request is accepted, each level of the division appends
// one copy per quotient step, ends with one failed subtract check and is closed by a tail
// step; then the rotation removes the leading rests one bit per cycle, ends with one
// rotation check, and the pattern is loaded into the output register. Trivial requests
// skip the division and the rotation and go straight to the output. Requests are served
// one at a time; a finished pattern waits in the output register while the next request
// is taken. Depends on erg_pkg, erg_ctrl and erg_dp.
module euclidean_rhythm_generator import erg_pkg::*; #(
  parameter int unsigned MAX_STEPS = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [CntW-1:0] step_count_i,
  input  logic [CntW-1:0] onsets_i,
  input  logic            anti_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [PatW-1:0] pattern_o
);

  erg_cmd_t    cmd;
  erg_status_t status;

  erg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  erg_dp #(
    .MaxSteps (MAX_STEPS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_count_i (step_count_i),
    .onsets_i     (onsets_i),
    .anti_i       (anti_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .pattern_o    (pattern_o)
  );

endmodule

// ----- design/erg_ctrl.sv -----
// Controller of the Euclidean rhythm generator.
// Sequences load, division, level tail, rotation and output; depends on erg_pkg.
module erg_ctrl import erg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  erg_status_t status_i,
  output erg_cmd_t    cmd_o
);

  erg_state_e state_q, state_d;
  logic       valid_q, valid_d;

  always_comb begin
    state_d = state_q;
    valid_d = valid_q;
    cmd_o   = '0;
    if (valid_q && out_ready_i) begin
      valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.trivial ? ST_FIN : ST_DIV;
        end
      end
      ST_DIV: begin
        if (status_i.can_sub) begin
          cmd_o.div_step = 1'b1;
        end else begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        cmd_o.tail = 1'b1;
        state_d    = status_i.last_level ? ST_ROT : ST_DIV;
      end
      ST_ROT: begin
        if (status_i.lead_one) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.rot_step = 1'b1;
        end
      end
      ST_FIN: begin
        if (!valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          valid_d        = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = valid_q;

endmodule

// ----- design/erg_dp.sv -----
// Datapath of the Euclidean rhythm generator.
// Holds the level strings, the division registers and the output register; uses erg_pkg.
module erg_dp import erg_pkg::*; #(
  parameter int unsigned MaxSteps = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [CntW-1:0]     step_count_i,
  input  logic [CntW-1:0]     onsets_i,
  input  logic                anti_i,
  input  erg_cmd_t            cmd_i,
  output erg_status_t         status_o,
  output logic [PatW-1:0]     pattern_o
);

  logic [CntW-1:0] n_in, k_in, k_eff;
  logic [PatW-1:0] triv_pat;
  logic            trivial;

  logic [CntW-1:0] n_q, d_q, r_q, a_len_q, b_len_q, cur_len_q;
  logic            anti_q;
  logic [PatW-1:0] a_q, b_q, cur_q, pattern_q;

  logic [CntW-1:0] sub, piece_len, app_len;
  logic [CntW:0]   len_sum;
  logic [PatW-1:0] piece, appended, tail_val;
  logic [CntW-1:0] tail_len;

  always_comb begin
    n_in     = (step_count_i > CntW'(MaxSteps)) ? CntW'(MaxSteps) : step_count_i;
    k_in     = (onsets_i > n_in) ? n_in : onsets_i;
    trivial  = (n_in == '0) || (k_in == '0) || (k_in == n_in);
    triv_pat = ((k_in == n_in) && (k_in != '0)) ? low_mask(n_in) : '0;
    k_eff    = anti_i ? (n_in - k_in) : k_in;
  end

  always_comb begin
    sub       = (r_q == '0) ? CntW'(1) : r_q;
    piece     = cmd_i.tail ? b_q : a_q;
    piece_len = cmd_i.tail ? b_len_q : a_len_q;
    appended  = cur_q | (piece << cur_len_q);
    len_sum   = {1'b0, cur_len_q} + {1'b0, piece_len};
    app_len   = (len_sum > (CntW+1)'(PatW)) ? CntW'(PatW) : len_sum[CntW-1:0];
    tail_val  = (r_q != '0) ? appended : cur_q;
    tail_len  = (r_q != '0) ? app_len : cur_len_q;
  end

  assign status_o.trivial    = trivial;
  assign status_o.can_sub    = (d_q >= sub);
  assign status_o.last_level = (r_q <= CntW'(1));
  assign status_o.lead_one   = cur_q[0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q       <= n_in;
      anti_q    <= anti_i && !trivial;
      d_q       <= n_in - k_eff;
      r_q       <= k_eff;
      a_q       <= '0;
      a_len_q   <= CntW'(1);
      b_q       <= PatW'(1);
      b_len_q   <= CntW'(1);
      cur_q     <= triv_pat;
      cur_len_q <= '0;
    end
    if (cmd_i.div_step) begin
      cur_q     <= appended;
      cur_len_q <= app_len;
      d_q       <= d_q - sub;
    end
    if (cmd_i.tail) begin
      if (r_q <= CntW'(1)) begin
        cur_q <= tail_val & low_mask(n_q);
      end else begin
        b_q       <= a_q;
        b_len_q   <= a_len_q;
        a_q       <= tail_val;
        a_len_q   <= tail_len;
        cur_q     <= '0;
        cur_len_q <= '0;
        d_q       <= r_q;
        r_q       <= d_q;
      end
    end
    if (cmd_i.rot_step) begin
      cur_q <= cur_q >> 1;
    end
    if (cmd_i.out_load) begin
      pattern_q <= anti_q ? (~cur_q & low_mask(n_q)) : cur_q;
    end
  end

  assign pattern_o = pattern_q;

  a_div_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |=> d_q < $past(d_q))
    else $error("Division step did not reduce the dividend.");

  a_rot_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rot_step |-> cur_q != '0)
    else $error("Rotation started on an empty pattern.");

  a_out_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> (pattern_q & ~low_mask(n_q)) == '0)
    else $error("Pattern has onsets beyond the step count.");

endmodule
